>>> rtl/wdp_pkg.sv
// wdp_pkg: shared types and constants of the window dot product block
// op codes, configuration register indexes, arithmetic widths, sequencer states
// no dependencies
`default_nettype none

package wdp_pkg;

    // element and accumulator formats (signed q8.8 in, signed q24.16 out)
    localparam int DATA_WIDTH = 16;
    localparam int PROD_WIDTH = 2 * DATA_WIDTH;
    localparam int ACC_WIDTH  = 40;

    // item fields
    localparam int OP_WIDTH     = 2;
    localparam int ADDR_WIDTH   = 14;
    localparam int ORIGIN_WIDTH = 5;

    // configuration registers
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 6;
    localparam int DIM_WIDTH       = 6;
    localparam int CHAN_WIDTH      = 5;
    localparam int KDIM_WIDTH      = 3;

    // width of the origin offset and plane size products
    localparam int BASE_WIDTH = 12;

    localparam logic [OP_WIDTH-1:0] OP_WRITE_IMAGE  = 2'd0;
    localparam logic [OP_WIDTH-1:0] OP_WRITE_KERNEL = 2'd1;
    localparam logic [OP_WIDTH-1:0] OP_COMPUTE      = 2'd2;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IMAGE_HEIGHT  = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IMAGE_WIDTH   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_KERNEL_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_KERNEL_WIDTH  = 3'd4;

    localparam logic [DIM_WIDTH-1:0]  RST_IMAGE_HEIGHT  = 6'd32;
    localparam logic [DIM_WIDTH-1:0]  RST_IMAGE_WIDTH   = 6'd32;
    localparam logic [CHAN_WIDTH-1:0] RST_CHANNEL_COUNT = 5'd3;
    localparam logic [KDIM_WIDTH-1:0] RST_KERNEL_HEIGHT = 3'd3;
    localparam logic [KDIM_WIDTH-1:0] RST_KERNEL_WIDTH  = 3'd3;

    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SETUP  = 4'b0010,
        S_RUN    = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

endpackage

`default_nettype wire

>>> rtl/wdp_ram.sv
// wdp_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module wdp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/window_dot_product_top.sv
// window_dot_product_top: windowed multiply-accumulate over an image and a kernel store
// depends on wdp_pkg (types, constants) and wdp_ram (image and kernel stores)
//
// channel  direction  handshake                      payload
// in       input      i_in_valid / o_in_ready        i_op, i_element_address, i_element_value,
//                                                    i_origin_row, i_origin_col
// out      output     o_out_valid / i_out_ready      o_window_sum, o_window_error
// cfg      input      i_cfg_wr_en (no wait)          i_cfg_index, i_cfg_data
//
// a write beat is written to its store as it is taken; a compute beat runs through channels *
// kernel rows * kernel columns products to its result, paced by the single multiply-accumulate
// that takes one product a cycle from one read port per store
// a window past the image edge, or an empty kernel, skips the products and gives its result
// reset is synchronous, active low; it restores the register defaults and clears the
// accumulator; the stores keep their contents and need no clearing pass
// o_in_ready is high only while no compute is under way; write beats are taken while a
// result still waits on the out channel, a compute holds its result until the slot is free
`default_nettype none

module window_dot_product_top #(
    parameter int MAX_IMAGE_DIM  = 32,
    parameter int MAX_CHANNELS   = 16,
    parameter int MAX_KERNEL_DIM = 7
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    // input beats
    input  wire logic                                      i_in_valid,
    output logic                                           o_in_ready,
    input  wire logic [wdp_pkg::OP_WIDTH-1:0]              i_op,
    input  wire logic [wdp_pkg::ADDR_WIDTH-1:0]            i_element_address,
    input  wire logic signed [wdp_pkg::DATA_WIDTH-1:0]     i_element_value,
    input  wire logic [wdp_pkg::ORIGIN_WIDTH-1:0]          i_origin_row,
    input  wire logic [wdp_pkg::ORIGIN_WIDTH-1:0]          i_origin_col,
    // result beats
    output logic                                           o_out_valid,
    input  wire logic                                      i_out_ready,
    output logic signed [wdp_pkg::ACC_WIDTH-1:0]           o_window_sum,
    output logic                                           o_window_error,
    // configuration writes
    input  wire logic                                      i_cfg_wr_en,
    input  wire logic [wdp_pkg::CFG_INDEX_WIDTH-1:0]       i_cfg_index,
    input  wire logic [wdp_pkg::CFG_DATA_WIDTH-1:0]        i_cfg_data
);

    // store geometry follows from the maximum dimensions
    localparam int IMG_DEPTH = MAX_CHANNELS * MAX_IMAGE_DIM * MAX_IMAGE_DIM;
    localparam int KER_DEPTH = MAX_CHANNELS * MAX_KERNEL_DIM * MAX_KERNEL_DIM;
    localparam int IMG_AW    = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
    localparam int KER_AW    = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1;

    localparam int DW  = wdp_pkg::DATA_WIDTH;
    localparam int PW  = wdp_pkg::PROD_WIDTH;
    localparam int AW  = wdp_pkg::ACC_WIDTH;
    localparam int BW  = wdp_pkg::BASE_WIDTH;
    localparam int DMW = wdp_pkg::DIM_WIDTH;
    localparam int CHW = wdp_pkg::CHAN_WIDTH;
    localparam int KDW = wdp_pkg::KDIM_WIDTH;
    localparam int ORW = wdp_pkg::ORIGIN_WIDTH;

    // ---------------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------------
    logic [DMW-1:0] r_cfg_h, r_cfg_w;
    logic [CHW-1:0] r_cfg_nc;
    logic [KDW-1:0] r_cfg_kh, r_cfg_kw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_h  <= wdp_pkg::RST_IMAGE_HEIGHT;
            r_cfg_w  <= wdp_pkg::RST_IMAGE_WIDTH;
            r_cfg_nc <= wdp_pkg::RST_CHANNEL_COUNT;
            r_cfg_kh <= wdp_pkg::RST_KERNEL_HEIGHT;
            r_cfg_kw <= wdp_pkg::RST_KERNEL_WIDTH;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                wdp_pkg::CFG_IMAGE_HEIGHT:  r_cfg_h  <= i_cfg_data;
                wdp_pkg::CFG_IMAGE_WIDTH:   r_cfg_w  <= i_cfg_data;
                wdp_pkg::CFG_CHANNEL_COUNT: r_cfg_nc <= i_cfg_data[CHW-1:0];
                wdp_pkg::CFG_KERNEL_HEIGHT: r_cfg_kh <= i_cfg_data[KDW-1:0];
                wdp_pkg::CFG_KERNEL_WIDTH:  r_cfg_kw <= i_cfg_data[KDW-1:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    // oversized settings are clamped to the store geometry
    logic [DMW-1:0] h_eff, w_eff;
    logic [CHW-1:0] nc_eff;
    logic [KDW-1:0] kh_eff, kw_eff;

    assign h_eff  = (32'(r_cfg_h) > 32'(MAX_IMAGE_DIM)) ? DMW'(MAX_IMAGE_DIM) : r_cfg_h;
    assign w_eff  = (32'(r_cfg_w) > 32'(MAX_IMAGE_DIM)) ? DMW'(MAX_IMAGE_DIM) : r_cfg_w;
    assign nc_eff = (32'(r_cfg_nc) > 32'(MAX_CHANNELS)) ? CHW'(MAX_CHANNELS) : r_cfg_nc;
    assign kh_eff = (32'(r_cfg_kh) > 32'(MAX_KERNEL_DIM)) ? KDW'(MAX_KERNEL_DIM) : r_cfg_kh;
    assign kw_eff = (32'(r_cfg_kw) > 32'(MAX_KERNEL_DIM)) ? KDW'(MAX_KERNEL_DIM) : r_cfg_kw;

    // ---------------------------------------------------------------------
    // input beats and store writes
    // ---------------------------------------------------------------------
    wdp_pkg::t_state r_state, n_state;

    logic in_beat;
    logic img_we, ker_we;

    assign o_in_ready = (r_state == wdp_pkg::S_IDLE);
    assign in_beat    = i_in_valid && o_in_ready;

    // writes beyond the store are ignored, as is the unused op code
    assign img_we = in_beat && (i_op == wdp_pkg::OP_WRITE_IMAGE)
                 && (32'(i_element_address) < 32'(IMG_DEPTH));
    assign ker_we = in_beat && (i_op == wdp_pkg::OP_WRITE_KERNEL)
                 && (32'(i_element_address) < 32'(KER_DEPTH));

    // ---------------------------------------------------------------------
    // sequencer: walks channel, kernel row, kernel column
    // ---------------------------------------------------------------------
    logic [ORW-1:0]    r_org_row, r_org_col;
    logic [CHW-1:0]    r_ch, n_ch;
    logic [KDW-1:0]    r_row, n_row, r_col, n_col;
    logic [IMG_AW-1:0] r_img_idx, n_img_idx;   // image read address
    logic [IMG_AW-1:0] r_row_base, n_row_base; // first element of the current window row
    logic [IMG_AW-1:0] r_chan_base, n_chan_base;
    logic [IMG_AW-1:0] r_plane, n_plane;       // elements in one image channel
    logic [KER_AW-1:0] r_ker_idx, n_ker_idx;   // kernel read address, dense
    logic              r_err, n_err;
    logic [1:0]        r_pipe, n_pipe;         // read data valid, product valid
    logic              acc_clear;

    logic [BW-1:0]     origin_ofs;
    logic [BW-1:0]     plane_size;
    logic              edge_hit, empty_win;
    logic              last_col, last_row, last_ch;
    logic              issue;
    logic              result_load;
    logic [IMG_AW-1:0] w_step;

    assign origin_ofs = BW'(r_org_row) * BW'(w_eff) + BW'(r_org_col);
    assign plane_size = BW'(h_eff) * BW'(w_eff);
    assign w_step     = IMG_AW'(w_eff);

    // window past the image edge on either axis
    assign edge_hit  = (DMW'(r_org_row) + DMW'(kh_eff) > h_eff)
                    || (DMW'(r_org_col) + DMW'(kw_eff) > w_eff);
    assign empty_win = (nc_eff == '0) || (kh_eff == '0) || (kw_eff == '0);

    assign last_col = (r_col == KDW'(kw_eff - KDW'(1)));
    assign last_row = (r_row == KDW'(kh_eff - KDW'(1)));
    assign last_ch  = (r_ch == CHW'(nc_eff - CHW'(1)));

    assign issue       = (r_state == wdp_pkg::S_RUN);
    assign result_load = (r_state == wdp_pkg::S_FINISH) && (r_pipe == 2'b00)
                      && (!o_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        n_row       = r_row;
        n_col       = r_col;
        n_img_idx   = r_img_idx;
        n_row_base  = r_row_base;
        n_chan_base = r_chan_base;
        n_plane     = r_plane;
        n_ker_idx   = r_ker_idx;
        n_err       = r_err;
        n_pipe      = {r_pipe[0], issue};
        acc_clear   = 1'b0;

        unique case (r_state)
            wdp_pkg::S_IDLE: begin
                if (in_beat && (i_op == wdp_pkg::OP_COMPUTE)) begin
                    n_state = wdp_pkg::S_SETUP;
                end
            end
            wdp_pkg::S_SETUP: begin
                acc_clear   = 1'b1;
                n_err       = edge_hit;
                n_ch        = '0;
                n_row       = '0;
                n_col       = '0;
                n_ker_idx   = '0;
                n_img_idx   = IMG_AW'(origin_ofs);
                n_row_base  = IMG_AW'(origin_ofs);
                n_chan_base = IMG_AW'(origin_ofs);
                n_plane     = IMG_AW'(plane_size);
                if (edge_hit || empty_win) begin
                    n_state = wdp_pkg::S_FINISH;
                end else begin
                    n_state = wdp_pkg::S_RUN;
                end
            end
            wdp_pkg::S_RUN: begin
                n_ker_idx = r_ker_idx + KER_AW'(1);
                if (!last_col) begin
                    n_col     = r_col + KDW'(1);
                    n_img_idx = r_img_idx + IMG_AW'(1);
                end else if (!last_row) begin
                    n_col      = '0;
                    n_row      = r_row + KDW'(1);
                    n_row_base = r_row_base + w_step;
                    n_img_idx  = r_row_base + w_step;
                end else if (!last_ch) begin
                    n_col       = '0;
                    n_row       = '0;
                    n_ch        = r_ch + CHW'(1);
                    n_chan_base = r_chan_base + r_plane;
                    n_row_base  = r_chan_base + r_plane;
                    n_img_idx   = r_chan_base + r_plane;
                end else begin
                    n_state = wdp_pkg::S_FINISH;
                end
            end
            wdp_pkg::S_FINISH: begin
                // wait for the last products to drain and the out slot to free up
                if (result_load) begin
                    n_state = wdp_pkg::S_IDLE;
                end
            end
            default: n_state = wdp_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wdp_pkg::S_IDLE;
            r_pipe  <= 2'b00;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pipe  <= n_pipe;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_org_row <= i_origin_row;
            r_org_col <= i_origin_col;
        end
        r_ch        <= n_ch;
        r_row       <= n_row;
        r_col       <= n_col;
        r_img_idx   <= n_img_idx;
        r_row_base  <= n_row_base;
        r_chan_base <= n_chan_base;
        r_plane     <= n_plane;
        r_ker_idx   <= n_ker_idx;
    end

    // ---------------------------------------------------------------------
    // stores
    // ---------------------------------------------------------------------
    logic [DW-1:0] img_q, ker_q;

    wdp_ram #(
        .WIDTH (DW),
        .DEPTH (IMG_DEPTH)
    ) u_image_ram (
        .i_clk     (i_clk),
        .i_wr_en   (img_we),
        .i_wr_addr (IMG_AW'(i_element_address)),
        .i_wr_data (i_element_value),
        .i_rd_addr (r_img_idx),
        .o_rd_data (img_q)
    );

    wdp_ram #(
        .WIDTH (DW),
        .DEPTH (KER_DEPTH)
    ) u_kernel_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ker_we),
        .i_wr_addr (KER_AW'(i_element_address)),
        .i_wr_data (i_element_value),
        .i_rd_addr (r_ker_idx),
        .o_rd_data (ker_q)
    );

    // ---------------------------------------------------------------------
    // shared multiply-accumulate: product register, then saturating add
    // ---------------------------------------------------------------------
    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_acc;
    logic        [AW:0]   acc_sum;
    logic signed [AW-1:0] acc_sat;

    always_ff @(posedge i_clk) begin
        if (r_pipe[0]) begin
            r_prod <= $signed(img_q) * $signed(ker_q);
        end
    end

    // one guard bit; a carry into it that disagrees with the sign means overflow
    assign acc_sum = {r_acc[AW-1], r_acc} + {{(AW + 1 - PW){r_prod[PW-1]}}, r_prod};

    always_comb begin
        if (acc_sum[AW] != acc_sum[AW-1]) begin
            acc_sat = acc_sum[AW] ? wdp_pkg::ACC_MIN : wdp_pkg::ACC_MAX;
        end else begin
            acc_sat = $signed(acc_sum[AW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (acc_clear) begin
            r_acc <= '0;
        end else if (r_pipe[1]) begin
            r_acc <= acc_sat;
        end
    end

    // ---------------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------------
    logic                 r_out_valid;
    logic signed [AW-1:0] r_out_sum;
    logic                 r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result_load) begin
            r_out_sum <= r_acc;   // already zero on an edge error
            r_out_err <= r_err;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_window_sum   = r_out_sum;
    assign o_window_error = r_out_err;

`ifndef NO_ASSERTIONS
    // no product may still be in flight while new beats are taken
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_pipe == 2'b00))
        else $error("multiply-accumulate busy while accepting beats");

    // an edge error always carries a zero sum
    a_error_zero_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_window_error) |-> (o_window_sum == '0))
        else $error("error result with nonzero sum");

    // a compute beat starts the sequencer in the next cycle
    a_compute_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && (i_op == wdp_pkg::OP_COMPUTE)) |=> (r_state == wdp_pkg::S_SETUP))
        else $error("compute beat did not start the sequencer");

    // a result is only loaded into a free or draining out slot
    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_window_sum)))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
